// File: rtl/audio_format_list_negotiator_core_defines.svh
// ----------------------------------------------------------------------------
// Audio format list negotiator assertion macros
// Shared concurrent assertion helpers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_FORMAT_LIST_NEGOTIATOR_CORE_DEFINES_SVH
`define AUDIO_FORMAT_LIST_NEGOTIATOR_CORE_DEFINES_SVH

// Checks a property at every rising edge of clk_i outside of reset.
`define AFLN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("afln assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define AFLN_ASSERT_IMP(lbl, cond, cons) \
  `AFLN_ASSERT(lbl, (cond) |-> (cons))

`endif

// File: rtl/afln_pkg.sv
// ----------------------------------------------------------------------------
// Audio format list negotiator package
// Constants, codes and shared types of the sound-channel format negotiator.
// ----------------------------------------------------------------------------
package afln_pkg;

  localparam int POSITION_WIDTH_DEF = 16;

  localparam logic [7:0]  FORMATS_TYPE    = 8'h07;
  localparam int          COUNT_LO_POS    = 18;
  localparam int          COUNT_HI_POS    = 19;
  localparam int          RECORD_START    = 24;
  localparam int          MIN_POS         = 3;
  localparam int          MIN_FORMATS_POS = 23;

  localparam logic [4:0]  FIELDS_BYTES    = 5'd8;
  localparam logic [4:0]  EXTRA_LO_OFF    = 5'd16;
  localparam logic [4:0]  RECORD_LAST_OFF = 5'd17;

  localparam logic [15:0] ALAW_TAG        = 16'd6;
  localparam logic [15:0] PCM_TAG         = 16'd1;
  localparam logic [15:0] NO_TAG          = 16'd0;
  localparam logic [15:0] WANTED_CHANNELS = 16'd2;
  localparam logic [31:0] WANTED_RATE     = 32'd44100;

  localparam logic [2:0]  PCM_ALIGN       = 3'd4;
  localparam logic [2:0]  ALAW_ALIGN      = 3'd2;

  localparam logic        FMT_PCM         = 1'b0;
  localparam logic        FMT_ALAW        = 1'b1;

  localparam logic        STATUS_OK       = 1'b0;
  localparam logic        STATUS_SHORT    = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } afln_byte_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  message_type;
    logic        updated;
    logic        format_index;
    logic [15:0] format_tag;
    logic [2:0]  block_align;
    logic [15:0] fmt_count;
    logic        negotiated;
  } afln_result_t;

endpackage

// File: rtl/afln_ifs.sv
// ----------------------------------------------------------------------------
// Audio format list negotiator channel interfaces
// Valid/ready byte input channel and result output channel.
// ----------------------------------------------------------------------------
interface afln_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface afln_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  message_type;
  logic        updated;
  logic        format_index;
  logic [15:0] format_tag;
  logic [2:0]  block_align;
  logic [15:0] fmt_count;
  logic        negotiated;

  modport source (output valid, output status, output message_type, output updated,
                  output format_index, output format_tag, output block_align,
                  output fmt_count, output negotiated, input ready);
  modport sink   (input valid, input status, input message_type, input updated,
                  input format_index, input format_tag, input block_align,
                  input fmt_count, input negotiated, output ready);
endinterface

// File: rtl/afln_in_stage.sv
// ----------------------------------------------------------------------------
// Audio format list negotiator input stage
// Registers one PDU byte and releases it to the parser when it can advance.
// ----------------------------------------------------------------------------
module afln_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  afln_in_if.sink             in_i,
  input  logic                out_free_i,
  output logic                step_o,
  output afln_pkg::afln_byte_t byte_o
);
  import afln_pkg::*;

  logic       valid_q;
  afln_byte_t byte_q;

  // A byte that ends a PDU needs a free result register; others never wait.
  assign step_o   = valid_q && (!byte_q.last || out_free_i);
  assign in_i.ready = !valid_q || step_o;
  assign byte_o   = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q.data_byte <= in_i.data_byte;
      byte_q.last      <= in_i.last;
    end
  end

endmodule

// File: rtl/afln_parser.sv
// ----------------------------------------------------------------------------
// Audio format list negotiator parser
// Per-PDU parse state, format record checks and the persistent format choice.
// ----------------------------------------------------------------------------
module afln_parser #(
  parameter int POSITION_WIDTH = afln_pkg::POSITION_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_data_i,
  input  logic                  step_i,
  input  afln_pkg::afln_byte_t  byte_i,
  output logic                  res_valid_o,
  output afln_pkg::afln_result_t res_o
);
  import afln_pkg::*;

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  logic                      prefer_q;
  logic [POSITION_WIDTH-1:0] pos_q, pos_d;
  logic [7:0]                kind_q, kind_d;
  logic [15:0]               count_q, count_d;
  logic [15:0]               done_q, done_d;
  logic [4:0]                off_q, off_d;
  logic [15:0]               skip_q, skip_d;
  logic [63:0]               fields_q, fields_d;
  logic [15:0]               extra_q, extra_d;
  logic                      alaw_q, alaw_d;
  logic                      idx_q, idx_d;
  logic [2:0]                align_q, align_d;
  logic [15:0]               stored_q, stored_d;
  logic                      neg_q, neg_d;

  logic [7:0] b;
  logic       offer;
  logic       status;
  logic       updated;

  assign b = byte_i.data_byte;

  // The record being closed offers A-law at 2 channels and 44100 Hz.
  assign offer = (fields_q[15:0] == ALAW_TAG) && (fields_q[31:16] == WANTED_CHANNELS)
              && (fields_q[63:32] == WANTED_RATE);

  always_comb begin
    pos_d    = pos_q;
    kind_d   = kind_q;
    count_d  = count_q;
    done_d   = done_q;
    off_d    = off_q;
    skip_d   = skip_q;
    fields_d = fields_q;
    extra_d  = extra_q;
    alaw_d   = alaw_q;
    idx_d    = idx_q;
    align_d  = align_q;
    stored_d = stored_q;
    neg_d    = neg_q;
    status   = STATUS_OK;
    updated  = 1'b0;

    if (pos_q == '0) begin
      kind_d = b;
    end else if (pos_q == POSITION_WIDTH'(COUNT_LO_POS)) begin
      count_d = {8'h00, b};
    end else if (pos_q == POSITION_WIDTH'(COUNT_HI_POS)) begin
      count_d = {b, count_q[7:0]};
    end else if (pos_q >= POSITION_WIDTH'(RECORD_START) && kind_q == FORMATS_TYPE
                 && done_q < count_q) begin
      if (skip_q != 16'd0) begin
        skip_d = skip_q - 16'd1;
      end else begin
        if (off_q < FIELDS_BYTES) begin
          fields_d[8*off_q[2:0] +: 8] = b;
        end else if (off_q == EXTRA_LO_OFF) begin
          extra_d = {8'h00, b};
        end
        if (off_q >= RECORD_LAST_OFF) begin
          if (offer) begin
            alaw_d = 1'b1;
          end
          done_d   = done_q + 16'd1;
          skip_d   = {b, extra_q[7:0]};
          fields_d = '0;
          extra_d  = '0;
          off_d    = '0;
        end else begin
          off_d = off_q + 5'd1;
        end
      end
    end

    if (pos_q != POS_MAX) begin
      pos_d = pos_q + POSITION_WIDTH'(1);
    end

    // The choice sees a record that the last byte itself completes.
    if (byte_i.last) begin
      if (pos_q < POSITION_WIDTH'(MIN_POS)) begin
        status = STATUS_SHORT;
      end else if (kind_q == FORMATS_TYPE) begin
        if (pos_q < POSITION_WIDTH'(MIN_FORMATS_POS)) begin
          status = STATUS_SHORT;
        end else begin
          stored_d = count_q;
          if (prefer_q && alaw_d) begin
            idx_d   = FMT_ALAW;
            align_d = ALAW_ALIGN;
          end else begin
            idx_d   = FMT_PCM;
            align_d = PCM_ALIGN;
          end
          neg_d   = 1'b1;
          updated = 1'b1;
        end
      end
    end

    res_o.status       = status;
    res_o.message_type = kind_d;
    res_o.updated      = updated;
    res_o.format_index = idx_d;
    res_o.format_tag   = neg_d ? ((idx_d == FMT_ALAW) ? ALAW_TAG : PCM_TAG) : NO_TAG;
    res_o.block_align  = align_d;
    res_o.fmt_count    = stored_d;
    res_o.negotiated   = neg_d;

    // Every last byte starts the next PDU from a clean parse state.
    if (byte_i.last) begin
      pos_d    = '0;
      kind_d   = '0;
      count_d  = '0;
      done_d   = '0;
      off_d    = '0;
      skip_d   = '0;
      fields_d = '0;
      extra_d  = '0;
      alaw_d   = 1'b0;
    end
  end

  assign res_valid_o = step_i && byte_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefer_q <= 1'b0;
    end else if (cfg_we_i) begin
      prefer_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      kind_q   <= '0;
      count_q  <= '0;
      done_q   <= '0;
      off_q    <= '0;
      skip_q   <= '0;
      fields_q <= '0;
      extra_q  <= '0;
      alaw_q   <= 1'b0;
      idx_q    <= FMT_PCM;
      align_q  <= '0;
      stored_q <= '0;
      neg_q    <= 1'b0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      kind_q   <= kind_d;
      count_q  <= count_d;
      done_q   <= done_d;
      off_q    <= off_d;
      skip_q   <= skip_d;
      fields_q <= fields_d;
      extra_q  <= extra_d;
      alaw_q   <= alaw_d;
      idx_q    <= idx_d;
      align_q  <= align_d;
      stored_q <= stored_d;
      neg_q    <= neg_d;
    end
  end

endmodule

// File: rtl/afln_out_stage.sv
// ----------------------------------------------------------------------------
// Audio format list negotiator output stage
// Result register that holds one PDU result until the sink takes it.
// ----------------------------------------------------------------------------
module afln_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  res_valid_i,
  input  afln_pkg::afln_result_t res_i,
  afln_out_if.source            out_o,
  output logic                  out_free_o
);
  import afln_pkg::*;

  logic         valid_q;
  afln_result_t res_q;

  assign out_free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.status       = res_q.status;
  assign out_o.message_type = res_q.message_type;
  assign out_o.updated      = res_q.updated;
  assign out_o.format_index = res_q.format_index;
  assign out_o.format_tag   = res_q.format_tag;
  assign out_o.block_align  = res_q.block_align;
  assign out_o.fmt_count    = res_q.fmt_count;
  assign out_o.negotiated   = res_q.negotiated;

endmodule

// File: rtl/audio_format_list_negotiator_core.sv
// ----------------------------------------------------------------------------
// Audio format list negotiator core
// Parses sound-channel PDUs byte by byte and negotiates PCM or A-law output.
//
//   Channel   Direction  Moves                       Transactions
//   in_i      sink       data_byte, last             one per PDU byte
//   out_o     source     status ... negotiated       one per PDU, on last byte
//   cfg       write      prefer_compact (1 bit)      cfg_we_i strobe
//
// One byte per cycle is accepted while no last byte waits for the result
// register; a byte sits in the input register while the parser logic works
// on it, and the result of a last byte is captured in the result register.
// The result register alone decides stalls: only a last byte waits for it
// while a result is still not taken.
// Reset clears all parse state and the format choice; there is no sweep.
// ----------------------------------------------------------------------------
module audio_format_list_negotiator_core #(
  parameter int POSITION_WIDTH = afln_pkg::POSITION_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  afln_in_if.sink     in_i,
  afln_out_if.source  out_o
);
  import afln_pkg::*;

  logic         step;
  logic         out_free;
  logic         res_valid;
  afln_byte_t   cur_byte;
  afln_result_t res;

  afln_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_free_i (out_free),
    .step_o     (step),
    .byte_o     (cur_byte)
  );

  afln_parser #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .byte_i      (cur_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  afln_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_o       (out_o),
    .out_free_o  (out_free)
  );

endmodule

// File: rtl/afln_checker.sv
// ----------------------------------------------------------------------------
// Audio format list negotiator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "audio_format_list_negotiator_core_defines.svh"

module afln_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        status_i,
  input logic        updated_i,
  input logic        format_index_i,
  input logic [15:0] format_tag_i,
  input logic [2:0]  block_align_i,
  input logic        negotiated_i
);
  import afln_pkg::*;

  `AFLN_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)

  `AFLN_ASSERT_IMP(a_update_ok, out_valid_i && updated_i, negotiated_i && (status_i == STATUS_OK))

  `AFLN_ASSERT_IMP(a_short_no_update, out_valid_i && (status_i == STATUS_SHORT), !updated_i)

  // A negotiated choice is always one of the two consistent format settings.
  `AFLN_ASSERT_IMP(a_choice_consistent, out_valid_i && negotiated_i, ((format_index_i == FMT_PCM) && (format_tag_i == PCM_TAG) && (block_align_i == PCM_ALIGN)) || ((format_index_i == FMT_ALAW) && (format_tag_i == ALAW_TAG) && (block_align_i == ALAW_ALIGN)))

endmodule

bind audio_format_list_negotiator_core afln_checker u_afln_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .status_i       (out_o.status),
  .updated_i      (out_o.updated),
  .format_index_i (out_o.format_index),
  .format_tag_i   (out_o.format_tag),
  .block_align_i  (out_o.block_align),
  .negotiated_i   (out_o.negotiated)
);
